[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define BTPC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// clocked assertion that also holds during reset
`define BTPC_ASSERT_NR(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

[rtl/btpc_pkg.sv]
// ---------------------------------------------------------------------------
// Barometric compensation package
// Types, constants and helpers shared by the compensation block.
// ---------------------------------------------------------------------------
package btpc_pkg;

	localparam int unsigned CAL_W  = 48;
	localparam int unsigned RAW_W  = 20;

	localparam logic [1:0] CFG_TEMP     = 2'd0;
	localparam logic [1:0] CFG_PRESS_LO = 2'd1;
	localparam logic [1:0] CFG_PRESS_MD = 2'd2;
	localparam logic [1:0] CFG_PRESS_HI = 2'd3;

	localparam logic signed [63:0] TEMP_OFFS = 64'sd128000;
	localparam logic signed [63:0] F_BIAS    = 64'sd14073748835532800;
	// reciprocals for divide by 20 and by 100, exact for operands below 2^32
	localparam logic signed [63:0] C_RECIP   = 64'sd3435973837;
	localparam int unsigned        C_SHIFT   = 36;
	localparam logic signed [63:0] F_RECIP   = 64'sd1374389535;
	localparam int unsigned        F_SHIFT   = 37;
	localparam logic signed [63:0] P_SCALE   = 64'sd6250;
	localparam logic signed [63:0] P_LIM     = 64'sd2147483647;
	localparam logic signed [63:0] I32_MAX   = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN   = -64'sd2147483648;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// signed divide by 2^sh, truncating toward zero
	function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (v + bias) >>> sh;
	endfunction

	function automatic logic signed [63:0] sext16(input logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

endpackage

[rtl/btpc_alu.sv]
// ---------------------------------------------------------------------------
// Shared arithmetic unit
// Bit-serial 64-bit multiplier (low product) and signed truncating divider.
// ---------------------------------------------------------------------------
module btpc_alu import btpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  alu_req_t           req,
	input  logic signed [63:0] op_a,
	input  logic signed [63:0] op_b,
	output logic               done,
	output logic signed [63:0] result
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	alu_op_t     op_q;
	logic        neg_q;
	logic [64:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;

	logic [64:0] rem_sh;
	logic [65:0] diff;

	assign rem_sh = {acc_q[63:0], x_q[63]};
	assign diff   = {1'b0, rem_sh} - {2'b00, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			if (req.op == OP_MUL) begin
				neg_q <= 1'b0;
				x_q   <= op_a;
				y_q   <= op_b;
			end else begin
				neg_q <= op_a[63] ^ op_b[63];
				x_q   <= op_a[63] ? 64'(-op_a) : op_a;
				y_q   <= op_b[63] ? 64'(-op_b) : op_b;
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= {1'b0, acc_q[63:0] + (x_q[0] ? y_q : 64'd0)};
				x_q   <= x_q >> 1;
				y_q   <= y_q << 1;
			end else if (!diff[65]) begin
				acc_q <= diff[64:0];
				x_q   <= {x_q[62:0], 1'b1};
			end else begin
				acc_q <= rem_sh;
				x_q   <= {x_q[62:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == OP_MUL) ? $signed(acc_q[63:0])
		: (neg_q ? $signed(64'(-x_q)) : $signed(x_q));

endmodule

[rtl/baro_temp_pressure_compensation.sv]
// ---------------------------------------------------------------------------
// Barometric temperature / pressure compensation
// Applies the sensor calibration polynomials to raw 20-bit samples.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall carries kind, raw_sample, fahrenheit.
// Output channel out_valid/out_stall returns result_kind, value and
// divide_guard, one result per transaction.
// Calibration words are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// The polynomial multiplies and the divide run on one shared bit-serial 64-bit
// multiply/divide unit. A temperature item takes 4 operations, a pressure item
// 11, or stops once the divisor is found to be zero and sets divide_guard.
// in_stall is high from acceptance until the result is placed in the output
// register; a new item can be taken while that result waits on out_stall.
// A finished result waits while the output register still holds an earlier
// one under out_stall. Reset clears calibration, fine temperature and all
// control state.
// ---------------------------------------------------------------------------
module baro_temp_pressure_compensation import btpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CAL_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [RAW_W-1:0]    raw_sample,
	input  logic                fahrenheit,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic signed [31:0]  value,
	output logic                divide_guard
);

	typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN, ST_OUT} state_t;
	typedef enum logic [3:0] {
		S_T0, S_T1, S_T2, S_T3,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [CAL_W-1:0] temp_cal_q, pcal_lo_q, pcal_md_q, pcal_hi_q;
	logic signed [31:0] fine_q;

	logic             kind_q, fahr_q;
	logic [RAW_W-1:0] raw_q;
	logic signed [63:0] ax_q, aa_q, m_q, n_q, cf_q, tmp_q, p_q, e_q;
	logic signed [31:0] val_q;
	logic               guard_q;

	logic               out_valid_q, out_kind_q, out_guard_q;
	logic signed [31:0] out_value_q;

	alu_req_t           req;
	logic signed [63:0] opa, opb, res;
	logic               alu_done;

	logic signed [63:0] a_val, x_val, s_val, cf_next, p_clamp, fin_sum;
	logic signed [63:0] t_div, t_abs, t_quo;

	btpc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.op_a   (opa),
		.op_b   (opb),
		.done   (alu_done),
		.result (res)
	);

	assign a_val = {{32{fine_q[31]}}, fine_q} - TEMP_OFFS;
	assign x_val = sdiv_p2((($signed(64'd1048576) - $signed({44'd0, raw_q})) <<< 31) - m_q, 15);
	assign s_val = m_q + res;
	assign cf_next = sdiv_p2(res, 24);
	assign t_div = fahr_q ? sdiv_p2(m_q * 64'sd9 + F_BIAS, 34) : sdiv_p2(m_q, 34);
	assign t_abs = t_div[63] ? -t_div : t_div;
	assign t_quo = res >>> (fahr_q ? F_SHIFT : C_SHIFT);
	assign p_clamp = (res > P_LIM) ? P_LIM : ((res < -P_LIM) ? -P_LIM : res);
	assign fin_sum = p_q + sdiv_p2(e_q, 4);

	always_comb begin
		req.start = (state_q == ST_ISSUE);
		req.op    = OP_MUL;
		opa       = ax_q;
		opb       = ax_q;
		case (step_q)
			S_T0: opb = sext16(temp_cal_q[31:16]);
			S_T1: opb = ax_q;
			S_T2: begin opa = tmp_q; opb = sext16(temp_cal_q[47:32]); end
			S_T3: begin
				opa = t_abs;
				opb = fahr_q ? F_RECIP : C_RECIP;
			end
			S_P0: opb = ax_q;
			S_P1: begin opa = aa_q; opb = sext16(pcal_md_q[47:32]); end
			S_P2: opb = sext16(pcal_md_q[31:16]);
			S_P3: begin opa = aa_q; opb = sext16(pcal_lo_q[47:32]); end
			S_P4: opb = sext16(pcal_lo_q[31:16]);
			S_P5: begin opa = $signed({48'd0, pcal_lo_q[15:0]}); opb = sdiv_p2(n_q, 23); end
			S_P6: begin opa = x_val; opb = P_SCALE; end
			S_P7: begin req.op = OP_DIV; opa = tmp_q; opb = cf_q; end
			S_P8: begin opa = p_q; opb = p_q; end
			S_P9: begin opa = sext16(pcal_hi_q[47:32]); opb = sdiv_p2(tmp_q, 16); end
			S_P10: begin opa = p_q; opb = sext16(pcal_hi_q[31:16]); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pcal_lo_q  <= '0;
			pcal_md_q  <= '0;
			pcal_hi_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP:     temp_cal_q <= cfg_data;
				CFG_PRESS_LO: pcal_lo_q  <= cfg_data;
				CFG_PRESS_MD: pcal_md_q  <= cfg_data;
				CFG_PRESS_HI: pcal_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= S_T0;
			fine_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						raw_q   <= raw_sample;
						fahr_q  <= fahrenheit;
						guard_q <= 1'b0;
						step_q  <= kind ? S_P0 : S_T0;
						ax_q    <= kind ? a_val
							: ($signed({44'd0, raw_sample})
							- $signed({44'd0, temp_cal_q[15:0], 4'd0}));
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (alu_done) begin
						state_q <= ST_ISSUE;
						case (step_q)
							S_T0: begin m_q <= res <<< 20; step_q <= S_T1; end
							S_T1: begin tmp_q <= res; step_q <= S_T2; end
							S_T2: begin
								m_q    <= s_val;
								fine_q <= 32'(sdiv_p2(s_val, 34));
								step_q <= S_T3;
							end
							S_T3: begin
								val_q   <= 32'(t_div[63] ? -t_quo : t_quo);
								state_q <= ST_OUT;
							end
							S_P0: begin aa_q <= res; step_q <= S_P1; end
							S_P1: begin
								m_q    <= res + (sext16(pcal_md_q[15:0]) <<< 35);
								step_q <= S_P2;
							end
							S_P2: begin m_q <= m_q + (res <<< 17); step_q <= S_P3; end
							S_P3: begin n_q <= (64'sd1 <<< 55) + res; step_q <= S_P4; end
							S_P4: begin n_q <= n_q + (res <<< 20); step_q <= S_P5; end
							S_P5: begin
								cf_q   <= cf_next;
								step_q <= S_P6;
								if (cf_next == 64'sd0) begin
									val_q   <= '0;
									guard_q <= 1'b1;
									state_q <= ST_OUT;
								end
							end
							S_P6: begin tmp_q <= res; step_q <= S_P7; end
							S_P7: begin p_q <= p_clamp; step_q <= S_P8; end
							S_P8: begin tmp_q <= res; step_q <= S_P9; end
							S_P9: begin e_q <= sdiv_p2(res, 23); step_q <= S_P10; end
							S_P10: begin
								e_q <= e_q + sdiv_p2(res, 15)
									+ (sext16(pcal_hi_q[15:0]) <<< 8);
								state_q <= ST_FIN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FIN: begin
					val_q <= (fin_sum > I32_MAX) ? I32_MAX[31:0]
						: ((fin_sum < I32_MIN) ? I32_MIN[31:0] : fin_sum[31:0]);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= kind_q;
						out_value_q <= val_q;
						out_guard_q <= guard_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign result_kind  = out_kind_q;
	assign value        = out_value_q;
	assign divide_guard = out_guard_q;

endmodule

[rtl/btpc_checker.sv]
// ---------------------------------------------------------------------------
// Compensation block checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module btpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        result_kind,
	input logic [31:0] value,
	input logic        divide_guard
);

	`BTPC_ASSERT_NR(a_rst_idle, clk, !arst_n |=> !out_valid)
	`BTPC_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall)
	`BTPC_ASSERT(a_temp_no_guard, clk, arst_n, out_valid && !result_kind |-> !divide_guard)
	`BTPC_ASSERT(a_guard_zero, clk, arst_n, out_valid && divide_guard |-> value == 32'd0)
	`BTPC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_kind  (result_kind),
	.value        (value),
	.divide_guard (divide_guard)
);

[tb/baro_temp_pressure_compensation_tb.sv]
// ---------------------------------------------------------------------------
// Barometric compensation testbench
// Feeds temperature and pressure samples under several calibration sets.
// A compensation model in the bench predicts each result, and the results
// are checked in order. Both channels idle at random, and the output is
// held off once for a long stretch so that the block stalls its input.
// ---------------------------------------------------------------------------
module baro_temp_pressure_compensation_tb;
	import btpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 12000;

	typedef struct {
		logic              kind;
		logic signed [31:0] value;
		logic              guard;
	} comp_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_TEMP;
	logic [CAL_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = 1'b0;
	logic [RAW_W-1:0]   raw_sample = '0;
	logic               fahrenheit = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               result_kind;
	logic signed [31:0] value;
	logic               divide_guard;

	// bench copy of calibration and fine temperature
	logic [CAL_W-1:0]   cal_regs [4];
	logic signed [31:0] fine_temp;
	comp_result_t       pending_results [$];

	int mismatches = 0;
	int idle_cycles = 0;
	int hold_cycles = 0;
	int burst_left = 0;

	baro_temp_pressure_compensation dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint sword(input logic [CAL_W-1:0] r, input int sh);
		logic [15:0] w;
		w = r[sh +: 16];
		return longint'($signed(w));
	endfunction

	function automatic comp_result_t compensate(input logic k, input logic [19:0] r,
			input logic f);
		comp_result_t res;
		longint t1, t2, t3, d, s, two34;
		longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint a, aa, v2, n, cf, q, x, p, e1, e2, lim;
		res.kind = k;
		res.guard = 1'b0;
		two34 = 64'sd1 <<< 34;
		if (!k) begin
			t1 = longint'({48'd0, cal_regs[CFG_TEMP][15:0]});
			t2 = sword(cal_regs[CFG_TEMP], 16);
			t3 = sword(cal_regs[CFG_TEMP], 32);
			d = longint'({44'd0, r}) - 16 * t1;
			s = d * t2 * 1048576 + d * d * t3;
			fine_temp = 32'(s / two34);
			if (f)
				res.value = 32'((9 * s + 64'sd8192 * 100 * two34) / (100 * two34));
			else
				res.value = 32'(s / (20 * two34));
			return res;
		end
		p1 = longint'({48'd0, cal_regs[CFG_PRESS_LO][15:0]});
		p2 = sword(cal_regs[CFG_PRESS_LO], 16);
		p3 = sword(cal_regs[CFG_PRESS_LO], 32);
		p4 = sword(cal_regs[CFG_PRESS_MD], 0);
		p5 = sword(cal_regs[CFG_PRESS_MD], 16);
		p6 = sword(cal_regs[CFG_PRESS_MD], 32);
		p7 = sword(cal_regs[CFG_PRESS_HI], 0);
		p8 = sword(cal_regs[CFG_PRESS_HI], 16);
		p9 = sword(cal_regs[CFG_PRESS_HI], 32);
		a = longint'(fine_temp) - 128000;
		aa = a * a;
		v2 = aa * p6 + a * p5 * 131072 + p4 * (64'sd1 <<< 35);
		n = (64'sd1 <<< 55) + aa * p3 + a * p2 * 1048576;
		cf = (p1 * (n / 8388608)) / 16777216;
		if (cf == 0) begin
			res.value = 0;
			res.guard = 1'b1;
			return res;
		end
		q = (1048576 - longint'({44'd0, r})) * (64'sd1 <<< 31) - v2;
		x = q / 32768;
		lim = (64'sd1 <<< 31) - 1;
		p = (x * 6250) / cf;
		if (p > lim) p = lim;
		if (p < -lim) p = -lim;
		e1 = (p9 * ((p * p) / 65536)) / 8388608;
		e2 = (p * p8) / 32768;
		p = p + (e1 + e2 + p7 * 256) / 16;
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		res.value = 32'(p);
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		comp_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d value %0d guard %0d",
						result_kind, value, divide_guard);
			end else begin
				exp_res = pending_results.pop_front();
				if (result_kind !== exp_res.kind || value !== exp_res.value ||
						divide_guard !== exp_res.guard) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0d value %0d guard %0d, got %0d %0d %0d",
							exp_res.kind, exp_res.value, exp_res.guard,
							result_kind, value, divide_guard);
				end
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		int phase;
		phase = ($urandom_range(0, 999) < 300) ? 1 : 0;
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (($time / 24000) % 3 == 0) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= phase[0];
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_cal(input logic [1:0] idx, input logic [CAL_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		cal_regs[idx] = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(input logic [CAL_W-1:0] tc, input logic [CAL_W-1:0] pl,
			input logic [CAL_W-1:0] pm, input logic [CAL_W-1:0] ph);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		write_cal(CFG_TEMP, tc);
		write_cal(CFG_PRESS_LO, pl);
		write_cal(CFG_PRESS_MD, pm);
		write_cal(CFG_PRESS_HI, ph);
	endtask

	task automatic send_sample(input logic k, input logic [19:0] r, input logic f);
		in_valid <= 1'b1;
		kind <= k;
		raw_sample <= r;
		fahrenheit <= f;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(compensate(k, r, f));
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 8);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_random(input int count);
		logic [19:0] r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				// temperature then pressure, near typical readings
				r = 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
				send_sample(1'b0, r, 1'($urandom));
				r = 20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536;
				send_sample(1'b1, r, 1'($urandom));
				i++;
			end else begin
				send_sample(1'($urandom), 20'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic test_zero_calibration;
		// all words zero: pressure before any temperature hits the zero divisor
		send_sample(1'b1, 20'd415148, 1'b0);
		send_sample(1'b0, 20'h00000, 1'b0);
		send_sample(1'b0, 20'hFFFFF, 1'b1);
		send_sample(1'b1, 20'hFFFFF, 1'b1);
	endtask

	task automatic test_directed;
		load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
			{16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
		send_sample(1'b1, 20'd415148, 1'b0);
		send_sample(1'b0, 20'd519888, 1'b0);
		send_sample(1'b0, 20'd519888, 1'b1);
		send_sample(1'b1, 20'd415148, 1'b1);
		send_sample(1'b1, 20'h00000, 1'b0);
		send_sample(1'b1, 20'hFFFFF, 1'b0);
		send_sample(1'b0, 20'h00000, 1'b1);
		send_sample(1'b1, 20'd300000, 1'b0);
		send_sample(1'b0, 20'hFFFFF, 1'b0);
		send_sample(1'b1, 20'd300000, 1'b0);
		load_cal('1, '1, '1, '1);
		send_sample(1'b0, 20'hFFFFF, 1'b1);
		send_sample(1'b1, 20'h00000, 1'b0);
		send_sample(1'b0, 20'h00000, 1'b0);
		send_sample(1'b1, 20'hFFFFF, 1'b1);
		load_cal(48'h8000_7FFF_0000, 48'h8000_7FFF_FFFF, 48'h7FFF_8000_7FFF,
			48'h8000_7FFF_8000);
		send_sample(1'b0, 20'hFFFFF, 1'b0);
		send_sample(1'b1, 20'h00000, 1'b0);
		send_sample(1'b0, 20'h00000, 1'b1);
		send_sample(1'b1, 20'hFFFFF, 1'b0);
	endtask

	task automatic test_random_calibrations;
		load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
			{16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
		send_random(400);
		for (int ph = 0; ph < 3; ph++) begin
			load_cal({32'($urandom), 16'($urandom)}, {32'($urandom), 16'($urandom)},
				{32'($urandom), 16'($urandom)}, {32'($urandom), 16'($urandom)});
			send_random(230);
		end
		load_cal('0, '0, '0, '0);
		send_random(200);
	endtask

	task automatic test_output_holdoff;
		load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
			{16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
		hold_cycles = 3000;
		burst_left = 20;
		send_random(40);
	endtask

	initial begin
		for (int i = 0; i < 4; i++) cal_regs[i] = '0;
		fine_temp = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_calibration();
		test_directed();
		test_random_calibrations();
		test_output_holdoff();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
